/* src/obr_pkg.sv */
package obr_pkg;

    // fixed table and arithmetic constants
    localparam int TBL_SIZE = 8192;
    localparam int TBL_AW   = 13;

    localparam logic signed [19:0] PI_Q16     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic signed [31:0] ROT_COS    = 32'sd1073741508;
    localparam logic signed [31:0] ROT_SIN    = 32'sd823550;

    // register indexes on the configuration port
    localparam logic [2:0] REG_INTERP_COUNT  = 3'd0;
    localparam logic [2:0] REG_INV_INTERP    = 3'd1;
    localparam logic [2:0] REG_BAND_STEP     = 3'd2;
    localparam logic [2:0] REG_RADIAN_STEP   = 3'd3;
    localparam logic [2:0] REG_PARTIAL_COUNT = 3'd4;

    typedef struct packed {
        logic [6:0]  interp_count;
        logic [16:0] inv_interp;
        logic [28:0] band_step;
        logic [27:0] radian_step;
        logic [10:0] partial_count;
    } obr_cfg_t;

    typedef enum logic [4:0] {
        ST_INIT0, ST_INIT1, ST_INIT2, ST_INIT3, ST_INIT4,
        ST_IDLE, ST_RD, ST_MC, ST_MD, ST_ZERO, ST_F, ST_AI, ST_FI,
        ST_RUN, ST_DR1, ST_DR2, ST_WB, ST_E_RD, ST_E_LD, ST_E_WT
    } obr_state_t;

    // clamp a signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/obr_mul.sv */
module obr_mul (
    input  logic               aclk,
    input  logic signed [33:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [65:0] prod_reg
);

    logic signed [65:0] prod_next;

    // shared signed multiplier, product registered
    assign prod_next = 66'(op_a) * 66'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

/* src/obr_cfg.sv */
module obr_cfg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output obr_pkg::obr_cfg_t  cfg
);
    import obr_pkg::*;

    obr_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interp_count  <= 7'd64;
            cfg_reg.inv_interp    <= 17'd1024;
            cfg_reg.band_step     <= 29'd524288;
            cfg_reg.radian_step   <= 28'd333772;
            cfg_reg.partial_count <= 11'd512;
        end else if (wr_en) begin
            case (reg_idx)
                REG_INTERP_COUNT:  cfg_reg.interp_count  <= pwdata[6:0];
                REG_INV_INTERP:    cfg_reg.inv_interp    <= pwdata[16:0];
                REG_BAND_STEP:     cfg_reg.band_step     <= pwdata[28:0];
                REG_RADIAN_STEP:   cfg_reg.radian_step   <= pwdata[27:0];
                REG_PARTIAL_COUNT: cfg_reg.partial_count <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_INTERP_COUNT:  prdata = {25'd0, cfg_reg.interp_count};
            REG_INV_INTERP:    prdata = {15'd0, cfg_reg.inv_interp};
            REG_BAND_STEP:     prdata = {3'd0, cfg_reg.band_step};
            REG_RADIAN_STEP:   prdata = {4'd0, cfg_reg.radian_step};
            REG_PARTIAL_COUNT: prdata = {21'd0, cfg_reg.partial_count};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

/* src/oscillator_bank_resynth_unit.sv */
// per band: set-up in RD, MC, MD, F, AI and FI on the shared multiplier, then one
// oscillator step per cycle for min(interp_count, MAX_INTERP) steps, then DR1 and DR2
// drain and WB writes back; ignored or zero-magnitude bands skip the oscillator; a frame
// end then emits each sample through E_RD, E_LD and E_WT, holding in E_WT on output stall
// reset (aresetn low, synchronous) starts a pass that builds the cosine table and
// clears band and sample state; no transfer is taken meanwhile
module oscillator_bank_resynth_unit #(
    parameter int MAX_BANDS  = 1024,
    parameter int MAX_INTERP = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input band
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // band_index[9:0], magnitude[33:10], phase[52:34]
    input  logic        s_tlast,   // frame_end
    // output sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sample[31:0]
    output logic        m_tlast,   // last_sample
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import obr_pkg::*;

    localparam int BW = $clog2(MAX_BANDS);
    localparam int AW = (MAX_INTERP > 1) ? $clog2(MAX_INTERP) : 1;

    obr_cfg_t   cfg;
    obr_state_t state_reg, state_next;

    // memories
    logic [103:0]       band_mem [MAX_BANDS];
    logic [103:0]       bm_q;
    logic signed [15:0] cos_mem [TBL_SIZE];
    logic signed [15:0] cos_q;
    logic signed [47:0] acc_mem [MAX_INTERP];
    logic signed [47:0] acc_q;

    // input item registers
    logic [9:0]         band_reg;
    logic [23:0]        mag_reg;
    logic signed [18:0] ph_reg;
    logic               fe_reg;

    // init recurrence
    logic [TBL_AW-1:0]  idx_reg;
    logic signed [31:0] c_reg, s_reg, nc_reg;
    logic signed [65:0] t_reg;

    // band arithmetic
    logic signed [19:0] d_reg;
    logic [38:0]        centre_reg;
    logic [31:0]        f_reg;
    logic signed [48:0] ainc_reg, amp_reg;
    logic [44:0]        finc_reg, fr_reg;
    logic [28:0]        pos_reg;
    logic [6:0]         k_reg, e_reg;

    // oscillator pipeline
    logic signed [32:0] a1_reg;
    logic [AW-1:0]      s1_reg, s2_reg;
    logic               v1_reg, v2_reg;

    // output register
    logic [31:0]        out_data_reg;
    logic               out_last_reg, out_valid_reg;

    // multiplier
    logic signed [33:0] op_a;
    logic signed [31:0] op_b;
    logic signed [65:0] prod;

    // stored band fields
    logic [23:0]        pa;
    logic [31:0]        pf;
    logic signed [18:0] pp;
    logic [28:0]        tp;

    logic [6:0]         n_eff;
    logic               synth, take;
    logic [BW-1:0]      band_addr;
    logic [31:0]        band_ext;
    logic [31:0]        idx_ext;

    logic signed [19:0] d_raw, d_unw;
    logic signed [24:0] mag_diff;
    logic signed [32:0] f_diff;
    logic signed [65:0] rnd16;
    logic signed [49:0] q16;
    logic [31:0]        f_val;
    logic signed [65:0] init_sum;
    logic signed [65:0] init_rnd;
    logic signed [32:0] cos_sum;
    logic signed [17:0] cos_r;
    logic signed [15:0] cos_entry;
    logic signed [50:0] asum;
    logic signed [47:0] asat;
    logic signed [48:0] emit_sum;
    logic signed [40:0] emit_q;
    logic [31:0]        emit_val;

    // memory port controls
    logic               acc_we;
    logic [AW-1:0]      acc_wa, acc_ra;
    logic signed [47:0] acc_wd;
    logic               bm_we;
    logic [BW-1:0]      bm_wa;
    logic [103:0]       bm_wd;

    obr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    obr_mul u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod)
    );

    assign pa = bm_q[23:0];
    assign pf = bm_q[55:24];
    assign pp = bm_q[74:56];
    assign tp = bm_q[103:75];

    assign n_eff = (cfg.interp_count > 7'(MAX_INTERP)) ? 7'(MAX_INTERP) : cfg.interp_count;

    assign band_ext  = 32'(band_reg);
    assign band_addr = band_ext[BW-1:0];
    assign idx_ext   = 32'(idx_reg);
    assign synth     = ({1'b0, band_reg} < cfg.partial_count) && (band_ext < 32'(MAX_BANDS));

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // phase unwrap into plus/minus pi, one correction suffices for 19 bit inputs
    always_comb begin
        d_raw = 20'(ph_reg) - 20'(pp);
        if (d_raw > PI_Q16) begin
            d_unw = d_raw - TWO_PI_Q16;
        end else if (d_raw < -PI_Q16) begin
            d_unw = d_raw + TWO_PI_Q16;
        end else begin
            d_unw = d_raw;
        end
    end

    // set-up arithmetic
    assign mag_diff = $signed({1'b0, mag_reg}) - $signed({1'b0, pa});
    assign f_diff   = $signed({f_reg[31], f_reg}) - $signed({pf[31], pf});
    assign rnd16    = prod + 66'sd32768;
    assign q16      = rnd16[65:16];
    assign f_val    = sat32(64'(q16) + $signed({25'd0, centre_reg}));

    // cosine recurrence rounding
    assign init_sum = (state_reg == ST_INIT2) ? (t_reg - prod) : (t_reg + prod);
    assign init_rnd = init_sum + 66'sd536870912;
    assign cos_sum  = 33'(c_reg) + 33'sd16384;
    assign cos_r    = cos_sum[32:15];
    always_comb begin
        if (cos_r > 18'sd32767) begin
            cos_entry = 16'sh7fff;
        end else if (cos_r < -18'sd32768) begin
            cos_entry = -16'sh8000;
        end else begin
            cos_entry = cos_r[15:0];
        end
    end

    // accumulator add with 48 bit saturation
    assign asum = 51'(acc_q) + prod[50:0];
    always_comb begin
        if (asum[50:47] == 4'b0000 || asum[50:47] == 4'b1111) begin
            asat = asum[47:0];
        end else if (asum[50]) begin
            asat = {1'b1, 47'd0};
        end else begin
            asat = {1'b0, {47{1'b1}}};
        end
    end

    // output rounding and saturation
    assign emit_sum = 49'(acc_q) + 49'sd128;
    assign emit_q   = emit_sum[48:8];
    assign emit_val = sat32(64'(emit_q));

    // multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            ST_INIT0: begin
                op_a = 34'(c_reg);
                op_b = ROT_COS;
            end
            ST_INIT1: begin
                op_a = 34'(s_reg);
                op_b = ROT_SIN;
            end
            ST_INIT2: begin
                op_a = 34'(s_reg);
                op_b = ROT_COS;
            end
            ST_INIT3: begin
                op_a = 34'(c_reg);
                op_b = ROT_SIN;
            end
            ST_MC: begin
                op_a = $signed({24'd0, band_reg});
                op_b = $signed({3'd0, cfg.band_step});
            end
            ST_MD: begin
                op_a = 34'(d_reg);
                op_b = $signed({4'd0, cfg.radian_step});
            end
            ST_F: begin
                op_a = 34'(mag_diff);
                op_b = $signed({15'd0, cfg.inv_interp});
            end
            ST_AI: begin
                op_a = 34'(f_diff);
                op_b = $signed({15'd0, cfg.inv_interp});
            end
            ST_RUN, ST_DR1, ST_DR2: begin
                op_a = 34'(a1_reg);
                op_b = 32'(cos_q);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT0: state_next = ST_INIT1;
            ST_INIT1: state_next = ST_INIT2;
            ST_INIT2: state_next = ST_INIT3;
            ST_INIT3: state_next = ST_INIT4;
            ST_INIT4: state_next = (idx_reg == TBL_AW'(TBL_SIZE - 1)) ? ST_IDLE : ST_INIT0;
            ST_IDLE:  state_next = take ? ST_RD : ST_IDLE;
            ST_RD: begin
                if (synth) begin
                    state_next = ST_MC;
                end else if (fe_reg && n_eff != 7'd0) begin
                    state_next = ST_E_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MC:    state_next = (mag_reg == 24'd0) ? ST_ZERO : ST_MD;
            ST_MD:    state_next = ST_F;
            ST_F:     state_next = ST_AI;
            ST_AI:    state_next = ST_FI;
            ST_FI:    state_next = (n_eff == 7'd0) ? ST_WB : ST_RUN;
            ST_RUN:   state_next = (k_reg == n_eff - 7'd1) ? ST_DR1 : ST_RUN;
            ST_DR1:   state_next = ST_DR2;
            ST_DR2:   state_next = ST_WB;
            ST_ZERO, ST_WB: begin
                state_next = (fe_reg && n_eff != 7'd0) ? ST_E_RD : ST_IDLE;
            end
            ST_E_RD:  state_next = ST_E_LD;
            ST_E_LD:  state_next = ST_E_WT;
            ST_E_WT: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_E_RD;
                end
            end
            default:  state_next = ST_INIT0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT0;
        end else begin
            state_reg <= state_next;
        end
    end

    // memory port controls
    always_comb begin
        acc_we = 1'b0;
        acc_wa = s2_reg;
        acc_wd = asat;
        acc_ra = s1_reg;
        bm_we  = 1'b0;
        bm_wa  = band_addr;
        bm_wd  = {pos_reg, ph_reg, f_reg, mag_reg};
        case (state_reg)
            ST_INIT0: begin
                acc_we = (idx_ext < 32'(MAX_INTERP));
                acc_wa = idx_ext[AW-1:0];
                acc_wd = '0;
                bm_we  = (idx_ext < 32'(MAX_BANDS));
                bm_wa  = idx_ext[BW-1:0];
                bm_wd  = '0;
            end
            ST_ZERO: begin
                bm_we = 1'b1;
                bm_wd = {tp, pp, sat32($signed({25'd0, prod[38:0]})), 24'd0};
            end
            ST_WB: bm_we = 1'b1;
            ST_E_RD: acc_ra = e_reg[AW-1:0];
            ST_E_LD: begin
                acc_we = 1'b1;
                acc_wa = e_reg[AW-1:0];
                acc_wd = '0;
            end
            default: acc_we = v2_reg;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[acc_wa] <= acc_wd;
        end
        acc_q <= acc_mem[acc_ra];
    end

    always_ff @(posedge aclk) begin
        if (bm_we) begin
            band_mem[bm_wa] <= bm_wd;
        end
        bm_q <= band_mem[band_addr];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_INIT0) begin
            cos_mem[idx_reg] <= cos_entry;
        end
        cos_q <= cos_mem[pos_reg[28:16]];
    end

    // pipeline and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_RUN);
            v2_reg <= v1_reg;
            if (state_reg == ST_E_LD) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            c_reg   <= 32'sd1073741824;
            s_reg   <= '0;
        end else begin
            case (state_reg)
                ST_INIT1: t_reg <= prod;
                ST_INIT2: nc_reg <= init_rnd[61:30];
                ST_INIT3: t_reg <= prod;
                ST_INIT4: begin
                    c_reg   <= nc_reg;
                    s_reg   <= init_rnd[61:30];
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_IDLE: begin
                    if (take) begin
                        band_reg <= s_tdata[9:0];
                        mag_reg  <= s_tdata[33:10];
                        ph_reg   <= s_tdata[52:34];
                        fe_reg   <= s_tlast;
                    end
                end
                ST_MC: d_reg <= d_unw;
                ST_MD: centre_reg <= prod[38:0];
                ST_F:  f_reg <= f_val;
                ST_AI: ainc_reg <= prod[48:0];
                ST_FI: begin
                    finc_reg <= prod[44:0];
                    amp_reg  <= $signed({9'd0, pa, 16'd0});
                    fr_reg   <= {pf[28:0], 16'd0};
                    pos_reg  <= tp;
                    k_reg    <= '0;
                end
                ST_RUN: begin
                    a1_reg  <= amp_reg[48:16];
                    s1_reg  <= k_reg[AW-1:0];
                    amp_reg <= amp_reg + ainc_reg;
                    fr_reg  <= fr_reg + finc_reg;
                    pos_reg <= pos_reg + fr_reg[44:16];
                    k_reg   <= k_reg + 7'd1;
                end
                ST_ZERO, ST_WB: e_reg <= '0;
                ST_E_LD: begin
                    out_data_reg <= emit_val;
                    out_last_reg <= (e_reg == n_eff - 7'd1);
                end
                ST_E_WT: begin
                    if (m_tready) begin
                        e_reg <= e_reg + 7'd1;
                    end
                end
                default: ;
            endcase
            if (state_reg == ST_RD) begin
                e_reg <= '0;
            end
            s2_reg <= s1_reg;
        end
    end

endmodule
